[rtl/core/bpa_pkg.sv]
// Shared types, sizes and search helpers for the bitmap page allocator.
package bpa_pkg;

   localparam int NUM_PAGES  = 4096;
   localparam int PAGE_BYTES = 4096;

   localparam int ADDR_W     = 48;
   localparam int CNT_OUT_W  = 13;
   localparam int CNT_W      = $clog2(NUM_PAGES + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_IDX_W = $clog2(NUM_PAGES);

   // bitmap word geometry: at least two rows so the row index is never empty
   localparam int WORD_BITS  = (NUM_PAGES <= 64) ? NUM_PAGES / 2 : 64;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int ROWS       = NUM_PAGES / WORD_BITS;
   localparam int ROW_W      = $clog2(ROWS);

   localparam logic [ADDR_W-1:0] BASE_RESET = ADDR_W'(48'h20_0000);

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] addr;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [ADDR_W-1:0]    page_addr;
      logic [CNT_OUT_W-1:0] free_count;
   } rsp_type;

   // lowest clear bit of a bitmap word
   function automatic logic [BIT_W-1:0] first_zero_bit(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

   // lowest row that still holds a free page
   function automatic logic [ROW_W-1:0] first_open_row(input logic [ROWS-1:0] full);
      logic [ROW_W-1:0] idx;
      idx = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (!full[i]) begin
            idx = ROW_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/core/bitmap_page_allocator_unit.sv]
// Top level of the bitmap first-fit page allocator.
//
// Keeps one used bit per page in a RAM of ROWS words of WORD_BITS bits, plus one
// "row full" flag and one "row written" flag per word in flip-flops. An allocate
// beat picks the lowest row that is not full, reads that word, takes its lowest
// clear bit, sets it and writes the word back; the result address is
// region_base + page * PAGE_BYTES (modulo 2^48), or zero with ok low when every
// page is used. A free beat subtracts region_base, drops the in-page offset and
// clears the page's bit; addresses below the base or beyond the last page return
// ok low and change nothing, and freeing a page that is already free keeps the
// count. Every beat gives one result with the free count after the operation.
// Each beat runs accept, RAM read, modify and write back, and result in turn; a
// refused beat (range, or no page free) skips the RAM steps. The block handles one
// beat at a time, so reads never see a write still in flight. A word never
// written since reset reads as all free, so no clearing pass is needed after
// reset. The next beat is accepted while a result still waits on rsp_stall.
// Configure region_base through csr_write_en / csr_write_data only while idle.
module bitmap_page_allocator_unit
   import bpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,

   input  logic              csr_write_en,
   input  logic [ADDR_W-1:0] csr_write_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD,
      S_MOD,
      S_OUT
   } state_type;

   state_type             state_ff,       state_in;
   logic                  func_ff,        func_in;
   logic                  ok_ff,          ok_in;
   logic [ROW_W-1:0]      row_ff,         row_in;
   logic [BIT_W-1:0]      bit_ff,         bit_in;
   logic [ADDR_W-1:0]     region_base_ff, region_base_in;
   logic [CNT_W-1:0]      pages_free_ff,  pages_free_in;
   logic [ROWS-1:0]       full_ff,        full_in;
   logic [ROWS-1:0]       row_valid_ff,   row_valid_in;
   logic                  rsp_valid_ff,   rsp_valid_in;
   rsp_type               rsp_ff,         rsp_in;

   logic                  req_take;
   logic                  rsp_free;
   logic [ADDR_W-1:0]     offset;
   logic [PAGE_IDX_W-1:0] free_page;
   logic                  free_in_range;
   logic [WORD_BITS-1:0]  ram_rd_data;
   logic [WORD_BITS-1:0]  cur_word;
   logic [WORD_BITS-1:0]  new_word;
   logic [BIT_W-1:0]      alloc_bit;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     page_base;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // address decode for a free beat
   assign offset        = req_data.addr - region_base_ff;
   assign free_page     = offset[PAGE_SHIFT +: PAGE_IDX_W];
   assign free_in_range = (req_data.addr >= region_base_ff) &&
                          (offset[ADDR_W-1:PAGE_SHIFT+PAGE_IDX_W] == '0);

   // a row never written since reset holds all free pages
   assign cur_word  = row_valid_ff[row_ff] ? ram_rd_data : '0;
   assign alloc_bit = first_zero_bit(cur_word);

   always_comb begin
      new_word = cur_word;
      if (func_ff == FUNC_ALLOC) begin
         new_word[alloc_bit] = 1'b1;
      end else begin
         new_word[bit_ff] = 1'b0;
      end
   end

   assign ram_rd_en = (state_ff == S_RD);
   assign ram_wr_en = (state_ff == S_MOD);
   assign page_base = region_base_ff + (ADDR_W'({row_ff, bit_ff}) << PAGE_SHIFT);

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff),
      .wr_data (new_word),
      .rd_en   (ram_rd_en),
      .rd_addr (row_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      ok_in          = ok_ff;
      row_in         = row_ff;
      bit_in         = bit_ff;
      region_base_in = region_base_ff;
      pages_free_in  = pages_free_ff;
      full_in        = full_ff;
      row_valid_in   = row_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      // drop the held result once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         region_base_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in = req_data.func;
               if (req_data.func == FUNC_ALLOC) begin
                  ok_in    = !(&full_ff);
                  row_in   = first_open_row(full_ff);
                  bit_in   = '0;
                  state_in = (&full_ff) ? S_OUT : S_RD;
               end else begin
                  ok_in    = free_in_range;
                  row_in   = free_page[PAGE_IDX_W-1:BIT_W];
                  bit_in   = free_page[BIT_W-1:0];
                  state_in = free_in_range ? S_RD : S_OUT;
               end
            end
         end
         S_RD: begin
            state_in = S_MOD;
         end
         S_MOD: begin
            row_valid_in[row_ff] = 1'b1;
            full_in[row_ff]      = &new_word;
            if (func_ff == FUNC_ALLOC) begin
               bit_in = alloc_bit;
               if (pages_free_ff != '0) begin
                  pages_free_in = pages_free_ff - CNT_W'(1);
               end
            end else if (cur_word[bit_ff] && (pages_free_ff < CNT_W'(NUM_PAGES))) begin
               pages_free_in = pages_free_ff + CNT_W'(1);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.ok         = ok_ff;
               rsp_in.page_addr  = (ok_ff && (func_ff == FUNC_ALLOC)) ? page_base : '0;
               rsp_in.free_count = CNT_OUT_W'(pages_free_ff);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         region_base_ff <= BASE_RESET;
         pages_free_ff  <= CNT_W'(NUM_PAGES);
         full_ff        <= '0;
         row_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         region_base_ff <= region_base_in;
         pages_free_ff  <= pages_free_in;
         full_ff        <= full_in;
         row_valid_ff   <= row_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      func_ff <= func_in;
      ok_ff   <= ok_in;
      row_ff  <= row_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pages_free_ff <= CNT_W'(NUM_PAGES))
      else $error("free count above page count");

   a_full_needs_write: assert property (@(posedge clock) disable iff (reset)
      (full_ff & ~row_valid_ff) == '0)
      else $error("row flagged full but never written");

   a_alloc_decrements: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) && (func_ff == FUNC_ALLOC) |=>
         pages_free_ff == $past(pages_free_ff) - CNT_W'(1))
      else $error("allocation did not lower the free count");

   a_fail_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && (func_ff == FUNC_ALLOC) && !ok_ff |-> (&full_ff))
      else $error("allocation refused while a row has free pages");
`endif

endmodule

[rtl/core/bpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[test/testbench.sv]
// Self-checking testbench for the bitmap first-fit page allocator.
module testbench;
   import bpa_pkg::*;

   localparam int     HALF_PERIOD     = 6;
   localparam int     RESET_CYCLES    = 9;
   localparam int     RANDOM_BEATS    = 536;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     HOLD_OFF_BEATS  = 12;
   localparam int     SETTLE_CYCLES   = 8;
   localparam longint RUN_LIMIT       = 12_000_000;

   localparam logic [ADDR_W-1:0] ADDR_TOP    = '1;
   localparam logic [ADDR_W-1:0] PAGE_SPAN   = ADDR_W'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] REGION_SPAN = ADDR_W'(longint'(NUM_PAGES) * PAGE_BYTES);

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   req_type           req_data       = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b1;
   rsp_type           rsp_data;
   logic              csr_write_en   = 1'b0;
   logic [ADDR_W-1:0] csr_write_data = '0;

   // Shadow copy of the allocator: one used flag per page, the free count and the base.
   bit                page_used [NUM_PAGES];
   int                shadow_free;
   logic [ADDR_W-1:0] region_base;

   // Responses predicted at acceptance, oldest first.
   rsp_type awaited_responses [$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_left = 0;

   bitmap_page_allocator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Give up on a hung run; the bound is many times the slowest legal run.
   initial begin
      #RUN_LIMIT;
      $display("testbench: errors");
      $finish;
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   // Address of a page under the current base, wrapping at the top of the address space.
   function automatic logic [ADDR_W-1:0] page_address(input int idx);
      return region_base + ADDR_W'(idx) * PAGE_SPAN;
   endfunction

   // Apply one request to the shadow map and return the response it must produce.
   function automatic rsp_type apply_page_op(input req_type item);
      rsp_type           outcome;
      logic [ADDR_W-1:0] offset;
      longint unsigned   idx;
      outcome = '0;
      if (item.func == FUNC_ALLOC) begin
         // first fit: lowest clear flag wins; nothing found leaves ok low and address zero
         for (int i = 0; i < NUM_PAGES; i++) begin
            if (!page_used[i]) begin
               page_used[i]      = 1'b1;
               shadow_free       = shadow_free - 1;
               outcome.ok        = 1'b1;
               outcome.page_addr = page_address(i);
               break;
            end
         end
      end else if (item.addr >= region_base) begin
         // drop the in-page offset; anything past the last page is refused
         offset = item.addr - region_base;
         idx    = offset / PAGE_SPAN;
         if (idx < NUM_PAGES) begin
            outcome.ok = 1'b1;
            // a page that is already free keeps the count where it is
            if (page_used[idx]) begin
               page_used[idx] = 1'b0;
               shadow_free    = shadow_free + 1;
            end
         end
      end
      outcome.free_count = CNT_OUT_W'(shadow_free);
      return outcome;
   endfunction

   // Offer one beat, idling at random first, and predict its response once it is taken.
   // Valid is left high on return so back-to-back beats need no second assignment.
   task automatic send_beat(input logic func, input logic [ADDR_W-1:0] addr);
      req_type item;
      item.func = func;
      item.addr = addr;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      // hold the payload until the block takes it
      do @(posedge clock); while (req_stall);
      awaited_responses.push_back(apply_page_op(item));
   endtask

   // Drop valid and wait until every predicted response has been checked.
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
   endtask

   // Write the base only once the block is idle; every beat returns a response,
   // so an empty queue means nothing is still in flight.
   task automatic write_region_base(input logic [ADDR_W-1:0] value);
      wait_for_responses();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      region_base    = value;
   endtask

   // Short directed run on the reset base: each request kind and each corner of the free path.
   task automatic test_directed();
      send_beat(FUNC_FREE, region_base);                   // free a page never handed out
      send_beat(FUNC_ALLOC, '0);
      send_beat(FUNC_ALLOC, ADDR_TOP);                     // address field ignored on allocate
      send_beat(FUNC_ALLOC, rand_addr());
      send_beat(FUNC_FREE, page_address(1) + ADDR_W'(123)); // misaligned: the containing page goes
      send_beat(FUNC_ALLOC, '0);                           // lowest hole is refilled first
      send_beat(FUNC_FREE, region_base - 1);               // just below the base
      send_beat(FUNC_FREE, '0);
      send_beat(FUNC_FREE, region_base + REGION_SPAN);     // first byte past the last page
      send_beat(FUNC_FREE, region_base + REGION_SPAN - 1); // last byte of the last page
      send_beat(FUNC_FREE, ADDR_TOP);
      send_beat(FUNC_FREE, page_address(2));
      send_beat(FUNC_FREE, page_address(2) + PAGE_SPAN - 1); // same page again
      send_beat(FUNC_ALLOC, '0);
      send_beat(FUNC_FREE, page_address(0));
      wait_for_responses();
   endtask

   // Base at both ends of the address space, including wrap-around of page addresses.
   task automatic test_base_extremes();
      write_region_base('0);
      send_beat(FUNC_ALLOC, '0);
      send_beat(FUNC_ALLOC, rand_addr());
      send_beat(FUNC_FREE, '0);
      send_beat(FUNC_FREE, REGION_SPAN - 1);
      send_beat(FUNC_FREE, REGION_SPAN);
      send_beat(FUNC_FREE, ADDR_TOP);
      write_region_base(ADDR_TOP);
      // page zero sits on the top byte, the next ones wrap past zero
      send_beat(FUNC_ALLOC, '0);
      send_beat(FUNC_ALLOC, '0);
      send_beat(FUNC_ALLOC, '0);
      send_beat(FUNC_FREE, ADDR_TOP);
      send_beat(FUNC_FREE, '0);                            // wrapped page lies below the base
      // region ends exactly at the top of the address space
      write_region_base(ADDR_TOP - REGION_SPAN + 1);
      send_beat(FUNC_FREE, ADDR_TOP);
      send_beat(FUNC_ALLOC, '0);
      write_region_base(BASE_RESET);
      wait_for_responses();
   endtask

   // Fresh base, then mostly well-formed traffic: allocations, and frees aimed at the
   // part of the map in use; the rest is noise, addresses just outside the region and its last byte.
   task automatic test_random(input int beats);
      int                roll;
      int                top_used;
      int                page;
      logic [ADDR_W-1:0] new_base;
      new_base = rand_addr();
      case ($urandom_range(2))
         0: new_base[PAGE_SHIFT-1:0] = '0;
         1: new_base = ADDR_W'($urandom_range(0, 1 << 24));
         default: ;
      endcase
      write_region_base(new_base);
      repeat (beats) begin
         top_used = -1;
         for (int i = NUM_PAGES - 1; i >= 0; i--) begin
            if (page_used[i]) begin
               top_used = i;
               break;
            end
         end
         roll = $urandom_range(99);
         if (roll < 45) begin
            send_beat(FUNC_ALLOC, rand_addr());
         end else if (roll < 85) begin
            page = $urandom_range(0, (top_used + 1 < NUM_PAGES) ? top_used + 1 : NUM_PAGES - 1);
            send_beat(FUNC_FREE, page_address(page) + ADDR_W'($urandom_range(0, PAGE_BYTES - 1)));
         end else if (roll < 93) begin
            send_beat(FUNC_FREE, rand_addr());
         end else begin
            case ($urandom_range(2))
               0: send_beat(FUNC_FREE, region_base - ADDR_W'($urandom_range(1, PAGE_BYTES)));
               1: send_beat(FUNC_FREE,
                            region_base + REGION_SPAN + ADDR_W'($urandom_range(0, PAGE_BYTES)));
               default: send_beat(FUNC_FREE, region_base + REGION_SPAN - 1);
            endcase
         end
      end
      wait_for_responses();
   endtask

   // Stall the response side for a long stretch while beats keep coming, so the block
   // backs up into its input; then pause the sender until everything is back.
   task automatic test_hold_off();
      send_beat(FUNC_ALLOC, rand_addr());
      // set on a rising edge, picked up by the receiver at the next falling edge
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (HOLD_OFF_BEATS) begin
         if ($urandom_range(1) == 0) begin
            send_beat(FUNC_ALLOC, rand_addr());
         end else begin
            send_beat(FUNC_FREE, page_address($urandom_range(0, 7)));
         end
      end
      wait_for_responses();
   endtask

   // Receiver: stall at random, or solidly while a hold-off is counting down.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare every response beat taken with the oldest prediction.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none outstanding: expected nothing, actual %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_data.ok !== want.ok) begin
               $display("%0t: ok expected %0d actual %0d", $time, want.ok, rsp_data.ok);
               error_count++;
            end
            if (rsp_data.page_addr !== want.page_addr) begin
               $display("%0t: page_addr expected %h actual %h",
                        $time, want.page_addr, rsp_data.page_addr);
               error_count++;
            end
            if (rsp_data.free_count !== want.free_count) begin
               $display("%0t: free_count expected %0d actual %0d",
                        $time, want.free_count, rsp_data.free_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      foreach (page_used[i]) page_used[i] = 1'b0;
      shadow_free = NUM_PAGES;
      region_base = BASE_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalling
      send_idle_pct = 8;
      recv_idle_pct = 76;
      test_directed();
      test_base_extremes();
      test_random(RANDOM_BEATS);

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 76;
      recv_idle_pct = 8;
      test_random(RANDOM_BEATS);
      test_hold_off();

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(RANDOM_BEATS);

      // catch any stray response after the last expected one
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
